[src/wbs_pkg.sv]
`timescale 1ns / 1ps

package wbs_pkg;

  localparam int unsigned SUM_BITS        = 27;
  localparam int unsigned WIN_W           = 16;
  localparam logic [WIN_W-1:0] WIN_DEFAULT = 16'd328;
  localparam int unsigned SCORE_W         = 16;
  localparam int unsigned SCORE_FRAC      = 15;
  localparam int unsigned BLOCK_MAX_DEF   = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_load_term;
    logic div_load_score;
    logic div_step;
    logic acc;
    logic out_load;
  } wbs_cmd_t;

  typedef struct packed {
    logic last;
    logic mag_zero;
    logic div_last_step;
    logic out_free;
  } wbs_status_t;

  function automatic int unsigned wbs_max(input int unsigned x, input int unsigned y);
    return (x > y) ? x : y;
  endfunction

endpackage

[src/wbs_div.sv]
`timescale 1ns / 1ps

module wbs_div import wbs_pkg::*; #(
  parameter int unsigned DW = 27,
  parameter int unsigned QW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [DW+QW-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  input  logic             step_i,
  output logic [QW-1:0]    quot_o,
  output logic             last_step_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] low_q, low_d;
  logic [DW-1:0] div_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   trial;
  logic          ge;

  // The partial remainder always stays below the divisor, so one bit is
  // brought down and at most one subtraction is needed per step.
  always_comb begin
    trial = {rem_q, low_q[QW-1]};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
    low_d = {low_q[QW-2:0], ge};
    cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CW'(QW);
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i[DW+QW-1:QW];
      low_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign quot_o      = low_q;
  assign last_step_o = (cnt_q == CW'(1));

endmodule

[src/wbs_datapath.sv]
`timescale 1ns / 1ps

module wbs_datapath import wbs_pkg::*; #(
  parameter int unsigned BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wbs_cmd_t                      cmd_i,
  output wbs_status_t                   status_o,
  input  logic                          cfg_we_i,
  input  logic [WIN_W-1:0]              cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_a_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_b_i,
  input  logic                          is_last_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [SCORE_W-1:0]            score_o,
  output logic                          empty_block_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned DEN_W = wbs_max(SB, WIN_W) + 1;
  localparam int unsigned PRD_W = SB + WIN_W;
  localparam int unsigned DW    = wbs_max(SUM_BITS, DEN_W);
  localparam int unsigned QW    = wbs_max(SB, SCORE_W);
  localparam int unsigned CNT_W = $clog2(BLOCK_MAX + 1);
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  logic [WIN_W-1:0]    win_q;
  logic [WIN_W-1:0]    win_eff;
  logic [SB-1:0]       mag_a_q, mag_b_q;
  logic [SB-1:0]       mag_a_d, mag_b_d;
  logic [SB-1:0]       diff;
  logic [PRD_W-1:0]    prod_q;
  logic [DEN_W-1:0]    den_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                last_q;
  logic                last_d;
  logic [SUM_BITS-1:0] w_sum_q, m_sum_q;
  logic [SUM_BITS:0]   w_add, m_add;
  logic [SUM_BITS-1:0] w_sat, m_sat;
  logic [DW+QW-1:0]    dividend;
  logic [DW-1:0]       divisor;
  logic [QW-1:0]       quot;
  logic                div_last_step;
  logic                out_valid_q;
  logic [SCORE_W-1:0]  score_q;
  logic                empty_q;
  logic                mag_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_DEFAULT;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  assign win_eff = (win_q == '0) ? WIN_DEFAULT : win_q;

  // The negation of the most negative sample wraps to itself, which read
  // as unsigned is exactly its magnitude.
  always_comb begin
    mag_a_d = sample_a_i[SB-1] ? SB'(~sample_a_i + 1'b1) : sample_a_i;
    mag_b_d = sample_b_i[SB-1] ? SB'(~sample_b_i + 1'b1) : sample_b_i;
    last_d  = is_last_i || (cnt_q == CNT_W'(BLOCK_MAX - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.accept) begin
      last_q <= last_d;
      cnt_q  <= last_d ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mag_a_q <= mag_a_d;
      mag_b_q <= mag_b_d;
    end
  end

  assign diff = (mag_a_q > mag_b_q) ? mag_a_q - mag_b_q : mag_b_q - mag_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PRD_W'(mag_b_q * win_eff);
      den_q  <= DEN_W'(diff) + DEN_W'(win_eff);
    end
  end

  always_comb begin
    if (cmd_i.div_load_score) begin
      dividend = (DW+QW)'({w_sum_q, {SCORE_FRAC{1'b0}}});
      divisor  = DW'(m_sum_q);
    end else begin
      dividend = (DW+QW)'(prod_q);
      divisor  = DW'(den_q);
    end
  end

  wbs_div #(
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (cmd_i.div_load_term | cmd_i.div_load_score),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .step_i      (cmd_i.div_step),
    .quot_o      (quot),
    .last_step_o (div_last_step)
  );

  // Both sums saturate; the weighted sum is then held at or below the
  // magnitude sum so the final ratio never exceeds one.
  always_comb begin
    m_add = {1'b0, m_sum_q} + (SUM_BITS+1)'(mag_b_q);
    w_add = {1'b0, w_sum_q} + (SUM_BITS+1)'(quot[SB-1:0]);
    m_sat = m_add[SUM_BITS] ? SUM_MAX : m_add[SUM_BITS-1:0];
    w_sat = w_add[SUM_BITS] ? SUM_MAX : w_add[SUM_BITS-1:0];
    if (w_sat > m_sat) begin
      w_sat = m_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_sum_q <= '0;
      m_sum_q <= '0;
    end else if (cmd_i.out_load) begin
      w_sum_q <= '0;
      m_sum_q <= '0;
    end else if (cmd_i.acc) begin
      w_sum_q <= w_sat;
      m_sum_q <= m_sat;
    end
  end

  assign mag_zero = (m_sum_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      score_q <= mag_zero ? '0 : quot[SCORE_W-1:0];
      empty_q <= mag_zero;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign score_o       = score_q;
  assign empty_block_o = empty_q;

  assign status_o.last          = last_q;
  assign status_o.mag_zero      = mag_zero;
  assign status_o.div_last_step = div_last_step;
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

endmodule

[src/wbs_ctrl.sv]
`timescale 1ns / 1ps

module wbs_ctrl import wbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  wbs_status_t status_i,
  output wbs_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_LDT  = 9'b000000100,
    S_DIVT = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_FIN  = 9'b000100000,
    S_LDS  = 9'b001000000,
    S_DIVS = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_LDT;
      end
      S_LDT: begin
        cmd_o.div_load_term = 1'b1;
        state_d             = S_DIVT;
      end
      S_DIVT: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last_step) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // An empty block has no ratio to compute.
        state_d = status_i.mag_zero ? S_OUT : S_LDS;
      end
      S_LDS: begin
        cmd_o.div_load_score = 1'b1;
        state_d              = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last_step) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[src/weighted_block_similarity_top.sv]
`timescale 1ns / 1ps

// Weighted block similarity: each request carries one pair of signed samples
// (a, b); the block accumulates |b| and the weighted term
// |b|*win/(||a|-|b||+win), and on the pair marked last (or the BLOCK_MAX-th
// pair of a block) it returns weighted_sum/magnitude_sum as a Q1.15 score,
// with empty_block set and score 0 when the block had no magnitude at all.
// A window register value of zero is treated as 328. Each pair passes
// through the shared radix-2 divider, which takes Q = max(SAMPLE_BITS, 16)
// steps for its term; a last pair then runs a second division of Q steps
// for the score (an empty block skips it) and then waits for as long as the
// output register stays stalled. One pair is in work at a time, and the next
// request is taken as soon as the previous result sits in the output
// register.
module weighted_block_similarity_top import wbs_pkg::*; #(
  parameter int unsigned BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [WIN_W-1:0]              cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_a_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_b_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SCORE_W-1:0]            score_o,
  output logic                          empty_block_o
);

  wbs_cmd_t    cmd;
  wbs_status_t status;

  wbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wbs_datapath #(
    .BLOCK_MAX   (BLOCK_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_a_i    (sample_a_i),
    .sample_b_i    (sample_b_i),
    .is_last_i     (is_last_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .score_o       (score_o),
    .empty_block_o (empty_block_o)
  );

endmodule

[src/wbs_checker.sv]
`timescale 1ns / 1ps

module wbs_checker import wbs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [SCORE_W-1:0] score_o,
  input logic               empty_block_o
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(score_o) && $stable(empty_block_o))
    else $error("result changed while stalled");

  // An empty block reports a zero score.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_block_o |-> score_o == '0)
    else $error("empty block with nonzero score");

  // The ratio never exceeds one.
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> score_o <= 16'd32768)
    else $error("score above one");

  // One pair is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // A result cannot appear in the cycle right after a request is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind weighted_block_similarity_top wbs_checker u_wbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .score_o       (score_o),
  .empty_block_o (empty_block_o)
);
